// ===== rtl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear table lookup - shared definitions
// Widths, codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Default table depth
  localparam int MAX_POINTS_DEF = 64;

  // Field widths
  localparam int COORD_W = 16;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  // Interpolation arithmetic: 33 x 17 signed product, 48-bit magnitude
  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + COORD_W;
  localparam int MAG_W  = PROD_W - 1;
  localparam int STEP_W = $clog2(MAG_W);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_POINT_COUNT = 1'b0;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  localparam logic STS_OK       = 1'b0;
  localparam logic STS_NO_TABLE = 1'b1;

  // -1.0 in Q16.16, returned with no table loaded
  localparam logic [VAL_W-1:0] NO_TABLE_VALUE = 32'hFFFF_0000;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // store the accepted write item
    logic load;      // latch the query point, clear search flags
    logic rd_en;     // read one table entry
    logic rd_first;  // that entry is entry 0
    logic eval;      // choose end, exact or interpolated case
    logic mul;       // form the product
    logic div_init;  // load the divider
    logic div_step;  // one quotient bit
    logic adjust;    // sign and add base value
    logic out_load;  // move the result to the output register
    logic no_table;  // result is the no-table answer
  } plt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interp;    // the query needs the division
    logic out_free;  // output register can take a result
  } plt_sts_t;

endpackage

// ===== rtl/plt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear table lookup - controller
// Sequences the table scan, the multiply, the divider and the output hand-off.
// ----------------------------------------------------------------------------
module plt_ctrl #(
  parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [plt_pkg::CNT_W-1:0] point_count,
  output plt_pkg::plt_cmd_t         cmd,
  output logic [AW-1:0]             rd_addr,
  input  plt_pkg::plt_sts_t         sts
);
  import plt_pkg::*;

  localparam int N_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_EVAL, S_MUL, S_DINIT, S_DIV, S_ADJ, S_FIN
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     last_r;
  logic [STEP_W-1:0] step_r;
  logic              no_table_r;
  logic [N_W-1:0]    n_cl;
  logic              accept;

  // Entries in use, a count above the depth counts as the depth
  always_comb begin
    if ({{(32-CNT_W){1'b0}}, point_count} > 32'(MAX_POINTS)) begin
      n_cl = N_W'(MAX_POINTS);
    end else begin
      n_cl = N_W'(point_count);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_addr  = addr_r;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = accept && (in_command == CMD_WRITE);
    cmd.load     = accept && (in_command == CMD_QUERY);
    cmd.rd_en    = (state_r == S_SCAN);
    cmd.rd_first = (state_r == S_SCAN) && (addr_r == '0);
    cmd.eval     = (state_r == S_EVAL);
    cmd.mul      = (state_r == S_MUL) && sts.interp;
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.adjust   = (state_r == S_ADJ);
    cmd.out_load = (state_r == S_FIN) && sts.out_free;
    cmd.no_table = no_table_r;
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      addr_r     <= '0;
      last_r     <= '0;
      step_r     <= '0;
      no_table_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && (in_command == CMD_QUERY)) begin
            addr_r <= '0;
            last_r <= AW'(n_cl - N_W'(1));
            if (n_cl == '0) begin
              no_table_r <= 1'b1;
              state_r    <= S_FIN;
            end else begin
              no_table_r <= 1'b0;
              state_r    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == last_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_EVAL;
        S_EVAL:  state_r <= S_MUL;
        S_MUL: begin
          state_r <= sts.interp ? S_DINIT : S_FIN;
        end
        S_DINIT: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(MAG_W - 1)) begin
            state_r <= S_ADJ;
          end
        end
        S_ADJ: state_r <= S_FIN;
        S_FIN: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Scan never runs past the last entry in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (addr_r <= last_r))
    else $error("table scan beyond last entry");

  // A query on a loaded table starts a scan of entry 0
  a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_QUERY) && (n_cl != '0))
      |=> ((state_r == S_SCAN) && (addr_r == '0)))
    else $error("query did not start table scan");

  // Divider runs only for an interpolated query
  a_div_interp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (sts.interp && !no_table_r))
    else $error("divider running without interpolation");

endmodule

// ===== rtl/plt_dp.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear table lookup - datapath
// Table memories, search registers, multiplier, radix-2 divider, output item.
// ----------------------------------------------------------------------------
module plt_dp #(
  parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plt_pkg::plt_cmd_t                 cmd,
  input  logic [AW-1:0]                     rd_addr,
  output plt_pkg::plt_sts_t                 sts,
  input  logic [plt_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [plt_pkg::COORD_W-1:0]       in_entry_coord,
  input  logic signed [plt_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [plt_pkg::COORD_W-1:0]       in_query_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [plt_pkg::VAL_W-1:0]  out_result_value,
  output logic                              out_status
);
  import plt_pkg::*;

  // Table memories
  logic [COORD_W-1:0]      bp_mem  [MAX_POINTS];
  logic signed [VAL_W-1:0] val_mem [MAX_POINTS];

  logic                      wr_ok;
  logic [COORD_W-1:0]        rdx_r;
  logic signed [VAL_W-1:0]   rdy_r;
  logic                      rv_r;
  logic                      rfirst_r;

  // Search state
  logic [COORD_W-1:0]        p_r;
  logic [COORD_W-1:0]        first_x_r, prev_x_r, x0_r, x1_r;
  logic signed [VAL_W-1:0]   first_y_r, prev_y_r, y0_r, y1_r, eq_y_r;
  logic                      eq_found_r, ge_found_r;

  // Evaluation and arithmetic
  logic                      below, above, interp_nxt;
  logic                      interp_r;
  logic signed [VAL_W-1:0]   res_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic [COORD_W-1:0]        dpt_r, dx_r;
  logic signed [COORD_W:0]   dpt_s;
  logic signed [PROD_W:0]    prod_full;
  logic signed [PROD_W-1:0]  product_r;
  logic [PROD_W-1:0]         prod_abs;
  logic                      neg_r;
  logic [MAG_W-1:0]          quo_r;
  logic [COORD_W-1:0]        rem_r;
  logic [COORD_W:0]          trial;
  logic                      q_bit;
  logic [VAL_W-1:0]          q_lo;

  // Output register
  logic                      out_valid_r;
  logic signed [VAL_W-1:0]   out_value_r;
  logic                      out_status_r;

  assign wr_ok = {{(32-IDX_W){1'b0}}, in_entry_index} < 32'(MAX_POINTS);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      bp_mem[AW'(in_entry_index)]  <= in_entry_coord;
      val_mem[AW'(in_entry_index)] <= in_entry_value;
    end
    if (cmd.rd_en) begin
      rdx_r <= bp_mem[rd_addr];
      rdy_r <= val_mem[rd_addr];
    end
  end

  // Read tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r     <= 1'b0;
      rfirst_r <= 1'b0;
    end else begin
      rv_r     <= cmd.rd_en;
      rfirst_r <= cmd.rd_first;
    end
  end

  // Search flags: first exact match, first entry at or above the point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_found_r <= 1'b0;
      ge_found_r <= 1'b0;
    end else if (cmd.load) begin
      eq_found_r <= 1'b0;
      ge_found_r <= 1'b0;
    end else if (rv_r) begin
      if (!eq_found_r && (rdx_r == p_r)) begin
        eq_found_r <= 1'b1;
      end
      if (!ge_found_r && (rdx_r >= p_r)) begin
        ge_found_r <= 1'b1;
      end
    end
  end

  // Search payload; prev holds the last entry once the scan ends
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r <= in_query_point;
    end
    if (rv_r) begin
      prev_x_r <= rdx_r;
      prev_y_r <= rdy_r;
      if (rfirst_r) begin
        first_x_r <= rdx_r;
        first_y_r <= rdy_r;
      end
      if (!eq_found_r && (rdx_r == p_r)) begin
        eq_y_r <= rdy_r;
      end
      if (!ge_found_r && (rdx_r >= p_r)) begin
        x0_r <= prev_x_r;
        y0_r <= prev_y_r;
        x1_r <= rdx_r;
        y1_r <= rdy_r;
      end
    end
  end

  // Case selection
  assign below      = (p_r < first_x_r);
  assign above      = (p_r > prev_x_r);
  assign interp_nxt = !below && !above && !eq_found_r;

  // Multiplier and divider datapath
  assign dpt_s     = {1'b0, dpt_r};
  assign prod_full = diff_r * dpt_s;
  assign prod_abs  = product_r[PROD_W-1] ? (-product_r) : product_r;
  assign trial     = {rem_r, quo_r[MAG_W-1]};
  assign q_bit     = (trial >= {1'b0, dx_r});
  assign q_lo      = neg_r ? (-quo_r[VAL_W-1:0]) : quo_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_r  <= below ? first_y_r : (above ? prev_y_r : eq_y_r);
      diff_r <= {y1_r[VAL_W-1], y1_r} - {y0_r[VAL_W-1], y0_r};
      dpt_r  <= p_r - x0_r;
      dx_r   <= x1_r - x0_r;
    end
    if (cmd.mul) begin
      product_r <= prod_full[PROD_W-1:0];
    end
    if (cmd.div_init) begin
      neg_r <= product_r[PROD_W-1];
      quo_r <= prod_abs[MAG_W-1:0];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? COORD_W'(trial - {1'b0, dx_r}) : trial[COORD_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], q_bit};
    end
    if (cmd.adjust) begin
      res_r <= y0_r + $signed(q_lo);
    end
  end

  // Interpolation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_r <= 1'b0;
    end else if (cmd.load) begin
      interp_r <= 1'b0;
    end else if (cmd.eval) begin
      interp_r <= interp_nxt;
    end
  end

  // Output item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r  <= cmd.no_table ? $signed(NO_TABLE_VALUE) : res_r;
      out_status_r <= cmd.no_table ? STS_NO_TABLE : STS_OK;
    end
  end

  assign sts.interp   = interp_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

  // An interior point always has an upper neighbour
  a_ge_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && interp_nxt) |-> ge_found_r)
    else $error("interpolation without upper neighbour");

  // Divisor is positive while dividing
  a_dx_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dx_r != '0))
    else $error("zero divisor in interpolation");

  // No result overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output item overwritten");

endmodule

// ===== rtl/piecewise_linear_table_lookup.sv =====
// ----------------------------------------------------------------------------
// Piecewise linear table lookup
// One-dimensional Q16.16 table with linear interpolation between breakpoints.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  in_      | in_valid / in_ready     | command, entry_index, entry_coord,
//           |                         | entry_value, query_point
//  out_     | out_valid / out_ready   | result_value, status
//  config   | psel/penable/pwrite     | paddr 0: point_count (7 bits)
//
//  A write item is stored as it is accepted. A query scans the n entries
//  in use one per cycle through the table memory's read port; the 48-step
//  radix-2 divider runs only for an interpolated answer, not for an end or
//  exact answer or with no table. Reset (rst_n low, synchronous) clears
//  control and point_count; table contents are undefined until written. A
//  stalled output holds one item while the next is accepted and worked on.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup #(
  parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [plt_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [plt_pkg::COORD_W-1:0]       in_entry_coord,
  input  logic signed [plt_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [plt_pkg::COORD_W-1:0]       in_query_point,
  // Result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [plt_pkg::VAL_W-1:0]  out_result_value,
  output logic                              out_status,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plt_pkg::APB_AW-1:0]        paddr,
  input  logic [plt_pkg::APB_DW-1:0]        pwdata,
  output logic [plt_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import plt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  logic [CNT_W-1:0] point_count_r;
  logic             reg_wr;
  plt_cmd_t         cmd;
  plt_sts_t         sts;
  logic [AW-1:0]    rd_addr;

  // Register port: point_count at byte address 0
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (reg_wr) begin
      point_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POINT_COUNT) ?
                  {{(APB_DW-CNT_W){1'b0}}, point_count_r} : '0;

  plt_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .point_count (point_count_r),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .sts         (sts)
  );

  plt_dp #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .sts              (sts),
    .in_entry_index   (in_entry_index),
    .in_entry_coord   (in_entry_coord),
    .in_entry_value   (in_entry_value),
    .in_query_point   (in_query_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

endmodule
